>>> rtl/rcr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the rectangle collision resolver.
// Depends on nothing; the front, back and top modules import it.
package rcr_pkg;

    localparam int COORD_BITS  = 16;
    localparam int SIZE_BITS   = 15;
    localparam int EXT_BITS    = COORD_BITS + 2;
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [SIZE_BITS-1:0]  dim_t;
    typedef logic signed [EXT_BITS-1:0]   ext_t;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

    typedef struct packed {
        logic   cmd;
        coord_t pos_x;
        coord_t pos_y;
        coord_t old_x;
        coord_t old_y;
        dim_t   size_w;
        dim_t   size_h;
    } in_item_t;

    typedef struct packed {
        coord_t new_x;
        coord_t new_y;
        logic   landed;
        logic   stop_x;
        logic   stop_y;
        logic   table_full;
    } out_item_t;

    typedef struct packed {
        op_t    op;
        coord_t pos_x;
        coord_t pos_y;
        coord_t old_x;
        coord_t old_y;
        dim_t   size_w;
        dim_t   half_w;
        dim_t   size_h;
    } job_t;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        dim_t   w;
        dim_t   h;
    } rect_t;

    typedef struct packed {
        logic walking;
        logic full;
    } bk_status_t;

    function automatic ext_t ext_c(input coord_t c);
        return ext_t'({{(EXT_BITS - COORD_BITS){c[COORD_BITS-1]}}, c});
    endfunction

    function automatic ext_t ext_d(input dim_t d);
        return ext_t'({{(EXT_BITS - SIZE_BITS){1'b0}}, d});
    endfunction

    function automatic coord_t sat_coord(input ext_t v);
        coord_t res;
        if (v > ext_c({1'b0, {(COORD_BITS - 1){1'b1}}})) begin
            res = {1'b0, {(COORD_BITS - 1){1'b1}}};
        end else if (v < ext_c({1'b1, {(COORD_BITS - 1){1'b0}}})) begin
            res = {1'b1, {(COORD_BITS - 1){1'b0}}};
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/rcr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rcr_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, decodes the command and queues jobs for the back end.
// Depends on rcr_pkg.
module rcr_front
    import rcr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_pop,
    output logic     q_valid,
    output job_t     q_job
);

    job_t       slot_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    job_t       job_in;

    always_comb begin
        job_in.op     = op_t'(s_data.cmd);
        job_in.pos_x  = s_data.pos_x;
        job_in.pos_y  = s_data.pos_y;
        job_in.old_x  = s_data.old_x;
        job_in.old_y  = s_data.old_y;
        job_in.size_w = s_data.size_w;
        job_in.half_w = s_data.size_w >> 1;
        job_in.size_h = s_data.size_h;
    end

    assign s_ready = (fill_reg != 2'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != 2'd0);
    assign q_job   = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

>>> rtl/rcr_back.sv
`timescale 1ns / 1ps
// Back end: owns the rectangle table, executes adds and walks the table for queries.
// Depends on rcr_pkg and rcr_ram.
module rcr_back
    import rcr_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    output bk_status_t status
);

    localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] issue_reg;
    logic                v1_reg;
    logic                va_reg;
    logic                vb_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    out_item_t           out_next;

    logic  out_free;
    logic  pop;
    logic  can_add;
    logic  ram_we;
    logic  rd_en;
    logic  issue_more;
    logic  walk_done;
    logic  load_out;
    logic  is_add;
    rect_t wr_rect;
    rect_t rd_rect;

    coord_t px_reg, py_reg, ox_reg, oy_reg;
    dim_t   mw_reg, sh_reg;
    logic   landed_reg, stopx_reg, stopy_reg;

    ext_t   t_a_reg, b2_a_reg, r2_a_reg, l2_a_reg;
    ext_t   t_b_reg, b2_b_reg, r2_b_reg, l2_b_reg;
    coord_t st_b_reg, sb_b_reg, sr_b_reg, sl_b_reg;
    logic   top_ok_reg, und_ok_reg, rt_ok_reg, lf_ok_reg;

    ext_t px_e, py_e;
    logic hov, vov, hit_top, hit_und, hit_rt, hit_lf;

    assign out_free   = !m_valid_reg || m_ready;
    assign is_add     = (q_job.op == OP_ADD);
    assign can_add    = (count_reg != CNT_BITS'(TABLE_DEPTH));
    assign issue_more = (issue_reg != count_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_free && !is_add) begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK: begin
                if (!issue_more && !v1_reg && !va_reg && !vb_reg) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        walk_done = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                pop = q_valid && out_free;
            end
            BK_WALK: begin
                rd_en     = issue_more;
                walk_done = !issue_more && !v1_reg && !va_reg && !vb_reg;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign q_pop    = pop;
    assign ram_we   = pop && is_add && can_add;
    assign load_out = (pop && is_add) || walk_done;

    assign wr_rect.cx = q_job.pos_x;
    assign wr_rect.cy = q_job.pos_y;
    assign wr_rect.w  = q_job.size_w;
    assign wr_rect.h  = q_job.size_h;

    rcr_ram #(
        .WIDTH ($bits(rect_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_BITS-1:0]),
        .wdata (wr_rect),
        .re    (rd_en),
        .raddr (issue_reg[ADDR_BITS-1:0]),
        .rdata (rd_rect)
    );

    // The mover's edges are folded into the entry's edges, so only the current
    // position remains to be compared once per entry.
    assign px_e    = ext_c(px_reg);
    assign py_e    = ext_c(py_reg);
    assign hov     = (r2_b_reg > px_e) && (l2_b_reg < px_e);
    assign vov     = (b2_b_reg > py_e) && (t_b_reg < py_e);
    assign hit_top = hov && top_ok_reg && (t_b_reg < py_e);
    assign hit_und = hov && und_ok_reg && (b2_b_reg > py_e);
    assign hit_rt  = vov && rt_ok_reg && (r2_b_reg > px_e);
    assign hit_lf  = vov && lf_ok_reg && (l2_b_reg < px_e);

    always_comb begin
        if (walk_done) begin
            out_next.new_x      = px_reg;
            out_next.new_y      = py_reg;
            out_next.landed     = landed_reg;
            out_next.stop_x     = stopx_reg;
            out_next.stop_y     = stopy_reg;
            out_next.table_full = 1'b0;
        end else begin
            out_next.new_x      = '0;
            out_next.new_y      = '0;
            out_next.landed     = 1'b0;
            out_next.stop_x     = 1'b0;
            out_next.stop_y     = 1'b0;
            out_next.table_full = !can_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            v1_reg      <= 1'b0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= rd_en;
            va_reg    <= v1_reg;
            vb_reg    <= va_reg;
            if (ram_we) begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            if (pop) begin
                issue_reg <= '0;
            end else if (rd_en) begin
                issue_reg <= issue_reg + CNT_BITS'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= out_next;
        end

        t_a_reg  <= ext_c(rd_rect.cy) - ext_d(rd_rect.h >> 1);
        b2_a_reg <= ext_c(rd_rect.cy) + ext_d(rd_rect.h >> 1) + ext_d(sh_reg);
        r2_a_reg <= ext_c(rd_rect.cx) + ext_d(rd_rect.w >> 1) + ext_d(mw_reg);
        l2_a_reg <= ext_c(rd_rect.cx) - ext_d(rd_rect.w >> 1) - ext_d(mw_reg);

        t_b_reg    <= t_a_reg;
        b2_b_reg   <= b2_a_reg;
        r2_b_reg   <= r2_a_reg;
        l2_b_reg   <= l2_a_reg;
        st_b_reg   <= sat_coord(t_a_reg);
        sb_b_reg   <= sat_coord(b2_a_reg);
        sr_b_reg   <= sat_coord(r2_a_reg);
        sl_b_reg   <= sat_coord(l2_a_reg);
        top_ok_reg <= (t_a_reg >= ext_c(oy_reg));
        und_ok_reg <= (b2_a_reg <= ext_c(oy_reg));
        rt_ok_reg  <= (r2_a_reg <= ext_c(ox_reg));
        lf_ok_reg  <= (l2_a_reg >= ext_c(ox_reg));

        if (pop) begin
            px_reg     <= q_job.pos_x;
            py_reg     <= q_job.pos_y;
            ox_reg     <= q_job.old_x;
            oy_reg     <= q_job.old_y;
            mw_reg     <= q_job.half_w;
            sh_reg     <= q_job.size_h;
            landed_reg <= 1'b0;
            stopx_reg  <= 1'b0;
            stopy_reg  <= 1'b0;
        end else if (vb_reg) begin
            if (hit_top) begin
                py_reg     <= st_b_reg;
                landed_reg <= 1'b1;
                stopy_reg  <= 1'b1;
            end else if (hit_und) begin
                py_reg    <= sb_b_reg;
                stopy_reg <= 1'b1;
            end else if (hit_rt) begin
                px_reg    <= sr_b_reg;
                stopx_reg <= 1'b1;
            end else if (hit_lf) begin
                px_reg    <= sl_b_reg;
                stopx_reg <= 1'b1;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign status.walking = (state_reg == BK_WALK);
    assign status.full    = !can_add;

endmodule

>>> rtl/rect_collision_resolver.sv
`timescale 1ns / 1ps
// Top level of the rectangle collision resolver: front queue, back-end table walker.
// Depends on rcr_pkg, rcr_front, rcr_back and rcr_ram.
//
//  Channel   Handshake           Payload     Beat carries
//  s_        s_valid / s_ready   in_item_t   add a rectangle or resolve a mover
//  m_        m_valid / m_ready   out_item_t  one result per input beat
//
// An add is written to the table and its result registered when the back end pops it. A
// query walks the used entries after the back end pops it: one entry per cycle leaves the
// table RAM's registered read port and passes two precompute stages before it updates the
// position; an empty table answers without a RAM read. The front queue holds two beats, so
// input is taken while the back end works or a result waits. Reset (aresetn, synchronous)
// empties the table count and the queue; the table needs no clearing pass.
module rect_collision_resolver
    import rcr_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic       q_valid;
    logic       q_pop;
    job_t       q_job;
    bk_status_t bk_status;

    rcr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_job   (q_job)
    );

    rcr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .status  (bk_status)
    );

    a_full_result_needs_full_table: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |-> bk_status.full
    ) else $error("table_full reported while the table has free slots");

    a_full_is_sticky: assert property (
        @(posedge aclk) disable iff (!aresetn)
        bk_status.full |=> bk_status.full
    ) else $error("table left the full state without reset");

    a_no_result_while_walking: assert property (
        @(posedge aclk) disable iff (!aresetn)
        bk_status.walking |-> !m_valid
    ) else $error("result pending while a query walks the table");

endmodule
